[hdl/csf_pkg.sv]
// shared constants and types of the circle scanline span fill unit
package csf_pkg;

    localparam int LAST_LINE   = 160;
    localparam int STORE_DEPTH = LAST_LINE + 1;
    localparam int ADDR_W      = 8;
    localparam int WORD_W      = 16;
    localparam int COORD_W     = 8;
    localparam int EDGE_MAX    = 255;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] data;
    } store_wr_t;

    typedef struct packed {
        logic               start;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] rad;
    } draw_cmd_t;

endpackage

[hdl/circle_scanline_span_fill_unit.sv]
// top level of the circle scanline span fill unit
// Keeps one 16-bit span word (left edge in 15..8, right edge in 7..0) for each scanline
// 0..160 in a registered-read ram, all zero after reset through per-line valid bits, so no
// clearing pass is needed. One item is worked at a time. A read passes from transfer to
// result through the ram read at transfer, a capture register and the output register. A draw
// walks the midpoint circle with at most one store write per cycle, four per walk step (lines
// outside 0..160 are not written), taking about 0.71*radius+1 steps; the single ram write port
// sets that rate. A finished result waits in the output register while the next item is taken.
module circle_scanline_span_fill_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        op,
    input  logic [csf_pkg::COORD_W-1:0] center_x,
    input  logic [csf_pkg::COORD_W-1:0] center_y,
    input  logic [csf_pkg::COORD_W-1:0] radius,
    input  logic [csf_pkg::ADDR_W-1:0]  line_index,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        is_read,
    output logic [csf_pkg::WORD_W-1:0]  line_word
);
    import csf_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DRAW,
        S_READ,
        S_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic              out_valid_reg, out_valid_next;
    logic              is_read_reg, is_read_next;
    logic [WORD_W-1:0] line_word_reg, line_word_next;
    logic              pend_read_reg, pend_read_next;
    logic [WORD_W-1:0] pend_word_reg, pend_word_next;
    logic              rd_ok_reg, rd_ok_next;

    logic              take;
    logic              rd_in_range;
    logic              out_free;
    draw_cmd_t         cmd;
    store_wr_t         wr;
    logic              walk_done;
    logic              rd_en;
    logic [WORD_W-1:0] rd_data;

    assign in_stall    = state_reg != S_IDLE;
    assign take        = in_valid && !in_stall;
    assign rd_in_range = line_index <= ADDR_W'(LAST_LINE);
    assign out_free    = !out_valid_reg || !out_stall;

    assign cmd.start = take && !op;
    assign cmd.cx    = center_x;
    assign cmd.cy    = center_y;
    assign cmd.rad   = radius;
    assign rd_en     = take && op && rd_in_range;

    csf_walk u_walk (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .wr    (wr),
        .done  (walk_done)
    );

    csf_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (line_index),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        is_read_next   = is_read_reg;
        line_word_next = line_word_reg;
        pend_read_next = pend_read_reg;
        pend_word_next = pend_word_reg;
        rd_ok_next     = rd_ok_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    rd_ok_next = rd_in_range;
                    state_next = op ? S_READ : S_DRAW;
                end
            end
            S_DRAW:
            begin
                if (walk_done)
                begin
                    pend_read_next = 1'b0;
                    pend_word_next = '0;
                    state_next     = S_DONE;
                end
            end
            S_READ:
            begin
                pend_read_next = 1'b1;
                pend_word_next = rd_ok_reg ? rd_data : '0;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    is_read_next   = pend_read_reg;
                    line_word_next = pend_word_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            is_read_reg   <= 1'b0;
            line_word_reg <= '0;
            pend_read_reg <= 1'b0;
            pend_word_reg <= '0;
            rd_ok_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            is_read_reg   <= is_read_next;
            line_word_reg <= line_word_next;
            pend_read_reg <= pend_read_next;
            pend_word_reg <= pend_word_next;
            rd_ok_reg     <= rd_ok_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign is_read   = is_read_reg;
    assign line_word = line_word_reg;

endmodule

[hdl/csf_ram.sv]
// generic single-port-write, registered-read ram
module csf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 161
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/csf_store.sv]
// span store: ram plus per-line valid bits so unwritten lines read as zero
module csf_store (
    input  logic                      clk,
    input  logic                      rst_n,
    input  csf_pkg::store_wr_t        wr,
    input  logic                      rd_en,
    input  logic [csf_pkg::ADDR_W-1:0] rd_addr,
    output logic [csf_pkg::WORD_W-1:0] rd_data
);
    import csf_pkg::*;

    logic [STORE_DEPTH-1:0] valid_reg;
    logic                   rd_valid_reg;
    logic [WORD_W-1:0]      ram_q;

    csf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? ram_q : '0;

endmodule

[hdl/csf_walk.sv]
// midpoint circle walker, at most one store write per cycle, four per step
module csf_walk (
    input  logic               clk,
    input  logic               rst_n,
    input  csf_pkg::draw_cmd_t cmd,
    output csf_pkg::store_wr_t wr,
    output logic               done
);
    import csf_pkg::*;

    logic              run_reg;
    logic [1:0]        sub_reg;
    logic [8:0]        xy_reg;
    logic [8:0]        yx_reg;
    logic signed [11:0] err_reg;
    logic [COORD_W-1:0] cx_reg;
    logic [COORD_W-1:0] cy_reg;

    logic signed [9:0]  half_s;
    logic signed [9:0]  ofs_s;
    logic signed [9:0]  line_s;
    logic signed [9:0]  left_s;
    logic signed [9:0]  right_s;
    logic [7:0]         left_c;
    logic [7:0]         right_c;
    logic               line_ok;

    logic signed [11:0] err_sub;
    logic signed [11:0] err_new;
    logic [8:0]         xy_new;
    logic [8:0]         yx_new;
    logic               cont;
    logic               last_sub;

    // line offset and half span for this sub-step
    always_comb
    begin
        if (sub_reg[1])
        begin
            ofs_s  = signed'({1'b0, xy_reg});
            half_s = signed'({1'b0, yx_reg});
        end
        else
        begin
            ofs_s  = signed'({1'b0, yx_reg});
            half_s = signed'({1'b0, xy_reg});
        end
        if (sub_reg[0])
        begin
            line_s = signed'({2'b00, cy_reg}) + ofs_s;
        end
        else
        begin
            line_s = signed'({2'b00, cy_reg}) - ofs_s;
        end
        left_s  = signed'({2'b00, cx_reg}) - half_s;
        right_s = signed'({2'b00, cx_reg}) + half_s;
        line_ok = !line_s[9] && (line_s[8:0] <= 9'(LAST_LINE));
    end

    function automatic logic [7:0] clamp_edge(input logic signed [9:0] v);
        logic [7:0] r;
        if (v[9])
        begin
            r = '0;
        end
        else if (v[8])
        begin
            r = 8'(EDGE_MAX);
        end
        else
        begin
            r = v[7:0];
        end
        return r;
    endfunction

    assign left_c  = clamp_edge(left_s);
    assign right_c = clamp_edge(right_s);

    assign wr.en   = run_reg && line_ok;
    assign wr.addr = line_s[ADDR_W-1:0];
    assign wr.data = {left_c, right_c};

    // step update
    always_comb
    begin
        err_sub = err_reg - ((signed'({3'b000, yx_reg}) <<< 1) - 12'sd1);
        yx_new  = yx_reg + 9'd1;
        if (err_sub[11])
        begin
            err_new = err_sub + ((signed'({3'b000, xy_reg}) <<< 1) - 12'sd2);
            xy_new  = xy_reg - 9'd1;
        end
        else
        begin
            err_new = err_sub;
            xy_new  = xy_reg;
        end
        cont = xy_new >= yx_new;
    end

    assign last_sub = sub_reg == 2'd3;
    assign done     = run_reg && last_sub && !cont;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            sub_reg <= '0;
            xy_reg  <= '0;
            yx_reg  <= '0;
            err_reg <= '0;
            cx_reg  <= '0;
            cy_reg  <= '0;
        end
        else if (cmd.start)
        begin
            run_reg <= 1'b1;
            sub_reg <= '0;
            xy_reg  <= {1'b0, cmd.rad};
            yx_reg  <= '0;
            err_reg <= signed'({4'b0000, cmd.rad});
            cx_reg  <= cmd.cx;
            cy_reg  <= cmd.cy;
        end
        else if (run_reg)
        begin
            sub_reg <= sub_reg + 2'd1;
            if (last_sub)
            begin
                xy_reg  <= xy_new;
                yx_reg  <= yx_new;
                err_reg <= err_new;
                run_reg <= cont;
            end
        end
    end

endmodule

[sim/circle_scanline_span_fill_unit_test.sv]
// self-checking testbench of the circle scanline span fill unit with its own span store predictor
module circle_scanline_span_fill_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_READ = 1'b1;
    localparam int   LAST    = csf_pkg::LAST_LINE;
    localparam int   W_MAX   = csf_pkg::EDGE_MAX;

    typedef struct packed {
        logic                       is_read;
        logic [csf_pkg::WORD_W-1:0] word;
    } span_result_t;

    typedef struct packed {
        logic                        op;
        logic [csf_pkg::COORD_W-1:0] cx;
        logic [csf_pkg::COORD_W-1:0] cy;
        logic [csf_pkg::COORD_W-1:0] rad;
        logic [csf_pkg::ADDR_W-1:0]  idx;
        logic                        typed;
        logic [csf_pkg::WORD_W-1:0]  word;
    } stim_row_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic                        op = OP_DRAW;
    logic [csf_pkg::COORD_W-1:0] center_x = '0;
    logic [csf_pkg::COORD_W-1:0] center_y = '0;
    logic [csf_pkg::COORD_W-1:0] radius = '0;
    logic [csf_pkg::ADDR_W-1:0]  line_index = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic                        is_read;
    logic [csf_pkg::WORD_W-1:0]  line_word;

    logic [csf_pkg::WORD_W-1:0] span_copy [0:LAST];
    span_result_t               pending_results [$];

    int err_count   = 0;
    int draw_count  = 0;
    int read_count  = 0;
    int check_count = 0;
    int idle_pct    = 0;
    int stall_pct   = 0;
    int hold_left   = 0;

    stim_row_t directed_rows [0:24] = '{
        '{OP_READ, 8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 16'h0000},
        '{OP_READ, 8'd0,   8'd0,   8'd0,   8'd160, 1'b1, 16'h0000},
        '{OP_READ, 8'd0,   8'd0,   8'd0,   8'd255, 1'b1, 16'h0000},
        '{OP_DRAW, 8'd10,  8'd20,  8'd0,   8'd0,   1'b1, 16'h0000},
        '{OP_READ, 8'd0,   8'd0,   8'd0,   8'd20,  1'b1, 16'h0A0A},
        '{OP_READ, 8'd0,   8'd0,   8'd0,   8'd19,  1'b1, 16'h0000},
        '{OP_DRAW, 8'd0,   8'd0,   8'd255, 8'd0,   1'b1, 16'h0000},
        '{OP_READ, 8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 16'h0000},
        '{OP_READ, 8'd0,   8'd0,   8'd0,   8'd160, 1'b0, 16'h0000},
        '{OP_DRAW, 8'd255, 8'd255, 8'd255, 8'd0,   1'b1, 16'h0000},
        '{OP_READ, 8'd0,   8'd0,   8'd0,   8'd160, 1'b0, 16'h0000},
        '{OP_READ, 8'd0,   8'd0,   8'd0,   8'd100, 1'b0, 16'h0000},
        '{OP_DRAW, 8'd128, 8'd80,  8'd40,  8'd0,   1'b1, 16'h0000},
        '{OP_READ, 8'd0,   8'd0,   8'd0,   8'd40,  1'b0, 16'h0000},
        '{OP_READ, 8'd0,   8'd0,   8'd0,   8'd80,  1'b0, 16'h0000},
        '{OP_READ, 8'd0,   8'd0,   8'd0,   8'd120, 1'b0, 16'h0000},
        '{OP_DRAW, 8'd255, 8'd160, 8'd1,   8'd0,   1'b1, 16'h0000},
        '{OP_READ, 8'd0,   8'd0,   8'd0,   8'd160, 1'b0, 16'h0000},
        '{OP_READ, 8'd0,   8'd0,   8'd0,   8'd159, 1'b0, 16'h0000},
        '{OP_READ, 8'd0,   8'd0,   8'd0,   8'd161, 1'b1, 16'h0000},
        '{OP_DRAW, 8'd0,   8'd255, 8'd0,   8'd0,   1'b1, 16'h0000},
        '{OP_DRAW, 8'd5,   8'd3,   8'd10,  8'd0,   1'b1, 16'h0000},
        '{OP_READ, 8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 16'h0000},
        '{OP_READ, 8'd0,   8'd0,   8'd0,   8'd13,  1'b0, 16'h0000},
        '{OP_READ, 8'd0,   8'd0,   8'd0,   8'd170, 1'b1, 16'h0000}
    };

    circle_scanline_span_fill_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .center_x   (center_x),
        .center_y   (center_y),
        .radius     (radius),
        .line_index (line_index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .is_read    (is_read),
        .line_word  (line_word)
    );

    always #10 clk = ~clk;

    function automatic logic [7:0] clip_edge(int v);
        if (v < 0)
            return 8'd0;
        if (v > W_MAX)
            return 8'(W_MAX);
        return 8'(v);
    endfunction

    function automatic void put_line(int ln, int lft, int rgt);
        if (ln >= 0 && ln <= LAST)
            span_copy[ln] = {clip_edge(lft), clip_edge(rgt)};
    endfunction

    // updates the span store copy and returns the result the item should give
    function automatic span_result_t predict_span(stim_row_t it);
        span_result_t res;
        int xr;
        int acc;
        int yr;
        int cx;
        int cy;
        res = '0;
        if (it.op == OP_DRAW)
        begin
            cx  = int'(it.cx);
            cy  = int'(it.cy);
            xr  = int'(it.rad);
            acc = int'(it.rad);
            yr  = 0;
            while (xr >= yr)
            begin
                put_line(cy - yr, cx - xr, cx + xr);
                put_line(cy + yr, cx - xr, cx + xr);
                put_line(cy - xr, cx - yr, cx + yr);
                put_line(cy + xr, cx - yr, cx + yr);
                acc = acc - (2 * yr - 1);
                yr  = yr + 1;
                if (acc < 0)
                begin
                    acc = acc + 2 * (xr - 1);
                    xr  = xr - 1;
                end
            end
        end
        else
        begin
            res.is_read = 1'b1;
            if (int'(it.idx) <= LAST)
                res.word = span_copy[it.idx];
        end
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        err_count++;
        if (err_count <= 100)
            $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // offers one item, waits for its transfer and records the expected result
    task automatic send_item(stim_row_t it);
        span_result_t res;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        op         <= it.op;
        center_x   <= it.cx;
        center_y   <= it.cy;
        radius     <= it.rad;
        line_index <= it.idx;
        do
            @(posedge clk);
        while (in_stall);
        res = predict_span(it);
        if (it.typed)
            res = {it.op == OP_READ, it.word};
        pending_results.push_back(res);
        if (it.op == OP_DRAW)
            draw_count++;
        else
            read_count++;
        @(negedge clk);
    endtask

    task automatic begin_phase(int idle, int stall, int hold);
        in_valid <= 1'b0;
        @(posedge clk);
        idle_pct  = idle;
        stall_pct = stall;
        hold_left = hold;
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        span_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected result is_read=%0b word=%h",
                                          is_read, line_word));
            else
            begin
                want = pending_results.pop_front();
                check_count++;
                if (is_read !== want.is_read)
                    report_mismatch($sformatf("is_read %b, expected %b", is_read, want.is_read));
                if (line_word !== want.word)
                    report_mismatch($sformatf("line_word %h, expected %h (is_read %b)",
                                              line_word, want.word, want.is_read));
            end
        end
    end

    initial
    begin
        #100_000_000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        stim_row_t it;
        int last_cy;
        int last_rad;
        int v;
        int waited;
        int idles [0:3];
        int stalls [0:3];
        idles  = '{0, 78, 0, 8};
        stalls = '{0, 0, 78, 8};
        last_cy  = 80;
        last_rad = 20;
        for (int i = 0; i <= LAST; i++)
            span_copy[i] = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i]);

        for (int ph = 0; ph < 4; ph++)
        begin
            // long receiver hold-off on the first mix so the unit backs up
            begin_phase(idles[ph], stalls[ph], (ph == 0) ? 400 : 0);
            for (int n = 0; n < 400; n++)
            begin
                it = '0;
                if ($urandom_range(99) < 40)
                begin
                    it.op = OP_DRAW;
                    it.cx = 8'($urandom_range(0, 255));
                    if ($urandom_range(99) < 75)
                        it.cy = 8'($urandom_range(0, LAST + 10));
                    else
                        it.cy = 8'($urandom_range(0, 255));
                    if ($urandom_range(99) < 85)
                        it.rad = 8'($urandom_range(0, 40));
                    else
                        it.rad = 8'($urandom_range(0, 255));
                    last_cy  = int'(it.cy);
                    last_rad = int'(it.rad);
                end
                else
                begin
                    it.op = OP_READ;
                    v = $urandom_range(99);
                    if (v < 70)
                        v = last_cy - last_rad - 2 + $urandom_range(0, 2 * last_rad + 4);
                    else if (v < 90)
                        v = $urandom_range(0, LAST);
                    else
                        v = $urandom_range(LAST + 1, 255);
                    if (v < 0)
                        v = 0;
                    if (v > 255)
                        v = 255;
                    it.idx = 8'(v);
                end
                send_item(it);
            end
        end
        in_valid <= 1'b0;

        waited = 0;
        while (pending_results.size() != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

        $display("sent %0d draws and %0d line reads under four handshake mixes", draw_count,
                 read_count);
        $display("checked %0d results, one long output hold-off included", check_count);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
